FILE: src/lsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsq_pkg;

    localparam int SIZE_W          = 11;
    localparam int MAX_COLUMNS_DEF = 1024;

    typedef logic [SIZE_W-1:0] t_size;

    localparam t_size SIZE_LIMIT      = t_size'(2047);
    localparam t_size ROW_LEN_RESET   = t_size'(1024);

    // smallest of three square sizes
    function automatic t_size min3(input t_size a, input t_size b, input t_size c);
        t_size m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

`default_nettype wire

FILE: src/lsq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsq_in_if;
    logic valid;
    logic ready;
    logic cell_bit;
    logic last_cell;

    modport source (output valid, output cell_bit, output last_cell, input ready);
    modport sink (input valid, input cell_bit, input last_cell, output ready);
endinterface

interface lsq_out_if
    import lsq_pkg::*;
;
    logic  valid;
    logic  ready;
    t_size largest_side;

    modport source (output valid, output largest_side, input ready);
    modport sink (input valid, input largest_side, output ready);
endinterface

interface lsq_cfg_if
    import lsq_pkg::*;
;
    logic  valid;
    logic  ready;
    t_size row_length;

    modport source (output valid, output row_length, input ready);
    modport sink (input valid, input row_length, output ready);
endinterface

`default_nettype wire

FILE: src/lsq_line_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lsq_line_store
    import lsq_pkg::*;
#(
    parameter int DEPTH  = MAX_COLUMNS_DEF,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_size             i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      t_size             o_rd_data
);

    t_size r_mem [DEPTH];
    t_size r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: src/lsq_dp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lsq_dp_cell
    import lsq_pkg::*;
(
    input  wire logic  i_bit,
    input  wire t_size i_up,
    input  wire t_size i_left,
    input  wire t_size i_upleft,
    output      t_size o_size
);

    t_size smallest;

    always_comb begin
        smallest = min3(i_up, i_left, i_upleft);
        if (!i_bit) begin
            o_size = '0;
        end else if (smallest == SIZE_LIMIT) begin
            o_size = SIZE_LIMIT;
        end else begin
            o_size = smallest + t_size'(1);
        end
    end

endmodule

`default_nettype wire

FILE: src/largest_square_of_ones_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Result: the result of a matrix appears on o_result in the cycle after the transfer
//   of the cell marked last.
// Throughput: one cell per cycle; the line store read for the next column is issued
//   as the current cell is taken, so the only stall is a result still waiting.
// Reset: synchronous, active low; clears control state and sets row_length to 1024.
//   The line store has no reset and no clearing pass; first-row cells ignore its data.
module largest_square_of_ones_unit
    import lsq_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lsq_in_if.sink     i_cell,
    lsq_cfg_if.sink    i_cfg,
    lsq_out_if.source  o_result
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LEN_W = $clog2(MAX_COLUMNS + 1);

    // configuration
    t_size r_row_length;

    // scan state
    logic             r_first_row;
    logic [COL_W-1:0] r_col;
    t_size            r_left;
    t_size            r_upleft;
    t_size            r_best;

    // result register
    logic  r_out_valid;
    t_size r_out_side;

    logic             in_ready;
    logic             accept;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W:0]   col_inc;
    logic             row_end;
    logic [COL_W-1:0] n_col;
    t_size            rd_data;
    t_size            up;
    t_size            left;
    t_size            upleft;
    t_size            size;
    t_size            n_best;

    // config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROW_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_row_length <= i_cfg.row_length;
        end
    end

    // Clamp row length into 1..MAX_COLUMNS.
    always_comb begin
        if (32'(r_row_length) > MAX_COLUMNS) begin
            eff_len = LEN_W'(MAX_COLUMNS);
        end else if (r_row_length == '0) begin
            eff_len = LEN_W'(1);
        end else begin
            eff_len = LEN_W'(r_row_length);
        end
    end

    // Take a cell unless a finished result is stuck in the output register.
    assign in_ready     = !r_out_valid || o_result.ready;
    assign i_cell.ready = in_ready;
    assign accept       = i_cell.valid && in_ready;

    assign col_inc = (LEN_W+1)'(r_col) + (LEN_W+1)'(1);
    assign row_end = col_inc >= (LEN_W+1)'(eff_len);

    // Next column drives the line store read so the up value is ready in time.
    always_comb begin
        if (!accept) begin
            n_col = r_col;
        end else if (i_cell.last_cell || row_end) begin
            n_col = '0;
        end else begin
            n_col = COL_W'(col_inc);
        end
    end

    lsq_line_store #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (size),
        .i_rd_addr (n_col),
        .o_rd_data (rd_data)
    );

    // Neighbors outside the matrix count as zero.
    assign up     = r_first_row ? '0 : rd_data;
    assign left   = (r_col == '0) ? '0 : r_left;
    assign upleft = (r_col == '0) ? '0 : r_upleft;

    lsq_dp_cell u_dp_cell (
        .i_bit    (i_cell.cell_bit),
        .i_up     (up),
        .i_left   (left),
        .i_upleft (upleft),
        .o_size   (size)
    );

    assign n_best = (size > r_best) ? size : r_best;

    // Advance scan state on each transfer; drop back to a fresh matrix after last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_row <= 1'b1;
            r_col       <= '0;
            r_left      <= '0;
            r_upleft    <= '0;
            r_best      <= '0;
        end else if (accept) begin
            r_col <= n_col;
            if (i_cell.last_cell) begin
                r_first_row <= 1'b1;
                r_left      <= '0;
                r_upleft    <= '0;
                r_best      <= '0;
            end else begin
                r_left   <= size;
                r_upleft <= up;
                r_best   <= n_best;
                if (row_end) begin
                    r_first_row <= 1'b0;
                end
            end
        end
    end

    // Output register: load on the last cell, hold until the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_cell.last_cell) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cell.last_cell) begin
            r_out_side <= n_best;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.largest_side = r_out_side;

endmodule

`default_nettype wire

FILE: src/lsq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lsq_checker
    import lsq_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_valid,
    input wire logic  i_in_ready,
    input wire logic  i_in_last,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_size i_out_side
);

    logic last_xfer;
    assign last_xfer = i_in_valid && i_in_ready && i_in_last;

    // a result only follows the transfer of a last cell
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid && !i_out_ready)) |-> $past(last_xfer))
        else $error("result without a last cell");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_xfer |=> i_out_valid)
        else $error("last cell gave no result");

    a_ready_only_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    a_side_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_side) <= MAX_COLUMNS))
        else $error("square side beyond row capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_side)))
        else $error("stalled result changed");

endmodule

bind largest_square_of_ones_unit lsq_checker #(
    .MAX_COLUMNS (MAX_COLUMNS)
) u_lsq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_in_last   (i_cell.last_cell),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_side  (o_result.largest_side)
);

`default_nettype wire
